// ===== sv/nscr_pkg.sv =====
// Shared types, constants and BCD helper functions for the nibble-serial clock register port.
package nscr_pkg;

	localparam int unsigned REG_COUNT = 16;
	localparam int unsigned IDX_W     = 4;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned NIB_W     = 4;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	localparam logic [IDX_W-1:0] REG_SECONDS = 4'd0;
	localparam logic [IDX_W-1:0] REG_MINUTES = 4'd1;
	localparam logic [IDX_W-1:0] REG_HOURS   = 4'd2;
	localparam logic [IDX_W-1:0] REG_DAY     = 4'd3;
	localparam logic [IDX_W-1:0] REG_MONTH   = 4'd4;
	localparam logic [IDX_W-1:0] REG_YEAR    = 4'd5;
	localparam logic [IDX_W-1:0] REG_WEEKDAY = 4'd6;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_HIGH = 3'b010,
		PH_LOW  = 3'b100
	} phase_t;

	typedef enum logic [1:0] {
		NIB_ZERO = 2'd0,
		NIB_HIGH = 2'd1,
		NIB_LOW  = 2'd2
	} nib_sel_t;

	typedef struct packed {
		logic     sel_load;
		logic     high_load;
		logic     store_wr;
		logic     out_load;
		nib_sel_t nib_sel;
	} ctl_cmd_t;

	typedef struct packed {
		logic [7:0] write_byte;
		logic [5:0] now_seconds;
		logic [5:0] now_minutes;
		logic [4:0] now_hours;
		logic [4:0] now_day;
		logic [3:0] now_month;
		logic [7:0] now_year;
		logic [2:0] now_weekday;
	} clk_item_t;

	// Two-digit BCD of a value below 100.
	function automatic logic [7:0] bcd_of(input logic [6:0] v);
		logic [3:0] tens;
		logic [6:0] rest;
		tens = 4'd0;
		rest = v;
		for (int i = 1; i < 10; i++) begin
			if (v >= 7'(i * 10)) begin
				tens = 4'(i);
				rest = v - 7'(i * 10);
			end
		end
		return {tens, rest[3:0]};
	endfunction

	function automatic logic [6:0] year_mod100(input logic [7:0] y);
		logic [7:0] r;
		if (y >= 8'd200) begin
			r = y - 8'd200;
		end else if (y >= 8'd100) begin
			r = y - 8'd100;
		end else begin
			r = y;
		end
		return r[6:0];
	endfunction

	// Weekday shifted by two, wrapped over seven days, counted from one.
	function automatic logic [6:0] weekday_code(input logic [2:0] w);
		logic [3:0] t;
		t = {1'b0, w} + 4'd2;
		if (t >= 4'd7) begin
			t = t - 4'd7;
		end
		return {3'b000, t} + 7'd1;
	endfunction

endpackage

// ===== sv/nscr_in_if.sv =====
// Request channel interface: access kind, data byte and clock inputs with valid/ready.
interface nscr_in_if import nscr_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] write_byte;
	logic [5:0] now_seconds;
	logic [5:0] now_minutes;
	logic [4:0] now_hours;
	logic [4:0] now_day;
	logic [3:0] now_month;
	logic [7:0] now_year;
	logic [2:0] now_weekday;

	modport source(output valid, op, write_byte, now_seconds, now_minutes, now_hours,
		now_day, now_month, now_year, now_weekday, input ready);
	modport sink(input valid, op, write_byte, now_seconds, now_minutes, now_hours,
		now_day, now_month, now_year, now_weekday, output ready);
endinterface

// ===== sv/nscr_out_if.sv =====
// Response channel interface: read nibble with valid/ready.
interface nscr_out_if import nscr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [NIB_W-1:0] read_nibble;

	modport source(output valid, read_nibble, input ready);
	modport sink(input valid, read_nibble, output ready);
endinterface

// ===== sv/nibble_serial_clock_registers_core.sv =====
// Top level of the nibble-serial clock register port: controller plus datapath.
// A read word is answered in the cycle after it is accepted, from a result register.
// Throughput: one word per cycle, reads or writes; a pending read result only stalls
// the request side when it is not taken in the same cycle.
// Reset (arst_n low, asynchronous): the phase returns to idle, the selected register and
// the pending high nibble clear, all sixteen store bytes clear and no result is valid.
module nibble_serial_clock_registers_core import nscr_pkg::*; (
	input logic clk,
	input logic arst_n,
	nscr_in_if.sink    req,
	nscr_out_if.source rsp
);

	// The access protocol walks three phases. A write while idle picks the register
	// from the low nibble of its byte. In the next phase a write latches a high nibble
	// and a read returns the high nibble of the selected register. In the last phase a
	// write stores the full byte and a read returns the low nibble; both go back to idle.

	ctl_cmd_t  cmd;
	clk_item_t item;

	// The controller owns the phase, the handshake and the valid flag of the result.
	nscr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_op     (req.op),
		.out_ready (rsp.ready),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.cmd       (cmd)
	);

	// Gather the payload of the request word for the datapath.
	assign item.write_byte  = req.write_byte;
	assign item.now_seconds = req.now_seconds;
	assign item.now_minutes = req.now_minutes;
	assign item.now_hours   = req.now_hours;
	assign item.now_day     = req.now_day;
	assign item.now_month   = req.now_month;
	assign item.now_year    = req.now_year;
	assign item.now_weekday = req.now_weekday;

	// The datapath holds the selection, pending nibble and store, and forms the
	// BCD view of the clock for registers 0 to 6.
	nscr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.item        (item),
		.read_nibble (rsp.read_nibble)
	);

endmodule

// ===== sv/nscr_ctrl.sv =====
// Phase state machine and handshake control of the nibble-serial clock register port.
module nscr_ctrl import nscr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_op,
	input  logic     out_ready,
	output logic     in_ready,
	output logic     out_valid,
	output ctl_cmd_t cmd
);

	phase_t state_q, state_nxt;
	logic   out_valid_q;
	logic   accept;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt     = state_q;
		cmd.sel_load  = 1'b0;
		cmd.high_load = 1'b0;
		cmd.store_wr  = 1'b0;
		cmd.out_load  = 1'b0;
		cmd.nib_sel   = NIB_ZERO;
		if (accept) begin
			if (in_op == OP_READ) begin
				cmd.out_load = 1'b1;
				case (state_q)
					PH_HIGH: begin
						cmd.nib_sel = NIB_HIGH;
						state_nxt   = PH_LOW;
					end
					PH_LOW: begin
						cmd.nib_sel = NIB_LOW;
						state_nxt   = PH_IDLE;
					end
					default: begin
						// A read while idle returns zero and leaves the phase alone.
						cmd.nib_sel = NIB_ZERO;
					end
				endcase
			end else begin
				case (state_q)
					PH_HIGH: begin
						cmd.high_load = 1'b1;
						state_nxt     = PH_LOW;
					end
					PH_LOW: begin
						cmd.store_wr = 1'b1;
						state_nxt    = PH_IDLE;
					end
					default: begin
						cmd.sel_load = 1'b1;
						state_nxt    = PH_HIGH;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= PH_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/nscr_dp.sv =====
// Datapath: register selection, pending nibble, byte store, BCD clock view and read register.
module nscr_dp import nscr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  ctl_cmd_t         cmd,
	input  clk_item_t        item,
	output logic [NIB_W-1:0] read_nibble
);

	logic [IDX_W-1:0]  sel_q;
	logic [NIB_W-1:0]  pend_q;
	logic [BYTE_W-1:0] store_q [REG_COUNT];
	logic [NIB_W-1:0]  nib_q;
	logic [BYTE_W-1:0] reg_val;
	logic [NIB_W-1:0]  nib_nxt;

	// Registers 0 to 6 show the clock inputs of the current access in BCD.
	always_comb begin
		case (sel_q)
			REG_SECONDS: reg_val = bcd_of({1'b0, item.now_seconds});
			REG_MINUTES: reg_val = bcd_of({1'b0, item.now_minutes});
			REG_HOURS:   reg_val = bcd_of({2'b00, item.now_hours});
			REG_DAY:     reg_val = bcd_of({2'b00, item.now_day});
			REG_MONTH:   reg_val = bcd_of({3'b000, item.now_month} + 7'd1);
			REG_YEAR:    reg_val = bcd_of(year_mod100(item.now_year));
			REG_WEEKDAY: reg_val = bcd_of(weekday_code(item.now_weekday));
			default:     reg_val = store_q[sel_q];
		endcase
	end

	always_comb begin
		case (cmd.nib_sel)
			NIB_HIGH: nib_nxt = reg_val[BYTE_W-1:NIB_W];
			NIB_LOW:  nib_nxt = reg_val[NIB_W-1:0];
			default:  nib_nxt = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q  <= '0;
			pend_q <= '0;
			for (int i = 0; i < REG_COUNT; i++) begin
				store_q[i] <= '0;
			end
		end else begin
			if (cmd.sel_load) begin
				sel_q <= item.write_byte[IDX_W-1:0];
			end
			if (cmd.high_load) begin
				pend_q <= item.write_byte[NIB_W-1:0];
			end
			if (cmd.store_wr) begin
				store_q[sel_q] <= {pend_q, item.write_byte[NIB_W-1:0]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			nib_q <= nib_nxt;
		end
	end

	assign read_nibble = nib_q;

endmodule

// ===== sv/nscr_chk.sv =====
// Port-level checker for the nibble-serial clock register port and its bind.
module nscr_chk import nscr_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             in_op,
	input logic             out_valid,
	input logic             out_ready,
	input logic [NIB_W-1:0] read_nibble
);

	logic rd_acc;
	logic wr_acc;

	assign rd_acc = in_valid && in_ready && (in_op == OP_READ);
	assign wr_acc = in_valid && in_ready && (in_op == OP_WRITE);

	// Every accepted read shows a result in the next cycle.
	a_read_answers: assert property (@(posedge clk) disable iff (!arst_n)
		rd_acc |=> out_valid)
		else $error("accepted read produced no result");

	// A write never produces a result.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		wr_acc |=> !out_valid)
		else $error("write produced a result");

	// The request side is only held off by a result that is not being taken.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("request side stalled without a pending result");

	// A stalled result keeps its value.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(read_nibble)))
		else $error("stalled result changed or vanished");

endmodule

bind nibble_serial_clock_registers_core nscr_chk u_nscr_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (req.valid),
	.in_ready    (req.ready),
	.in_op       (req.op),
	.out_valid   (rsp.valid),
	.out_ready   (rsp.ready),
	.read_nibble (rsp.read_nibble)
);

// ===== tb/sv/tb_nibble_serial_clock_registers_core.sv =====
// Self-checking testbench of the nibble-serial clock register port with a scoreboard class.
`timescale 1ns / 100ps

module tb_nibble_serial_clock_registers_core;
	import nscr_pkg::*;

	// The random part stops once this many request words have gone in. The last
	// stretch runs with both sides always willing, so the tail drains at full rate.
	localparam int unsigned TARGET_WORDS = 1300;
	localparam int unsigned SETTLE_WORDS = 150;
	// Longest correct silence is a sender gap plus a receiver stall and the wait
	// for a read result; this is many times that.
	localparam int unsigned QUIET_LIMIT  = 2000;

	// One request word: the access kind and the byte and clock fields it carries.
	typedef struct packed {
		logic      op;
		clk_item_t f;
	} access_t;

	// Tracks the port as the requests go in and holds the read nibbles still owed.
	class nibble_port_scoreboard;
		phase_t               phase;
		logic [IDX_W-1:0]     selected;
		logic [NIB_W-1:0]     high_latch;
		logic [BYTE_W-1:0]    store [REG_COUNT];
		logic [NIB_W-1:0]     nibbles_due [$];
		int unsigned          errors;

		function new();
			phase = PH_IDLE;
			selected = '0;
			high_latch = '0;
			foreach (store[i]) store[i] = '0;
			errors = 0;
		endfunction

		static function logic [7:0] to_bcd(int unsigned v);
			return 8'((((v / 10) & 15) << 4) | (v % 10));
		endfunction

		// What the selected register shows to a read carrying these clock inputs.
		function logic [7:0] register_view(clk_item_t f);
			case (selected)
				REG_SECONDS: return to_bcd(int'(f.now_seconds));
				REG_MINUTES: return to_bcd(int'(f.now_minutes));
				REG_HOURS:   return to_bcd(int'(f.now_hours));
				REG_DAY:     return to_bcd(int'(f.now_day));
				REG_MONTH:   return to_bcd(int'(f.now_month) + 1);
				REG_YEAR:    return to_bcd(int'(f.now_year) % 100);
				REG_WEEKDAY: return to_bcd(((int'(f.now_weekday) + 2) % 7) + 1);
				default:     return store[selected];
			endcase
		endfunction

		function void note_request(access_t a);
			logic [7:0] seen;
			seen = register_view(a.f);
			if (a.op == OP_READ) begin
				case (phase)
					PH_HIGH: begin
						nibbles_due.push_back(seen[7:4]);
						phase = PH_LOW;
					end
					PH_LOW: begin
						nibbles_due.push_back(seen[3:0]);
						phase = PH_IDLE;
					end
					default: begin
						nibbles_due.push_back('0);
					end
				endcase
			end else begin
				case (phase)
					PH_HIGH: begin
						high_latch = a.f.write_byte[3:0];
						phase = PH_LOW;
					end
					PH_LOW: begin
						store[selected] = {high_latch, a.f.write_byte[3:0]};
						phase = PH_IDLE;
					end
					default: begin
						selected = a.f.write_byte[3:0];
						phase = PH_HIGH;
					end
				endcase
			end
		endfunction

		function void check_response(logic [NIB_W-1:0] got);
			logic [NIB_W-1:0] want;
			if (nibbles_due.size() == 0) begin
				$error("read_nibble: expected no word, actual 0x%h", got);
				errors++;
			end else begin
				want = nibbles_due.pop_front();
				if (got !== want) begin
					$error("read_nibble: expected 0x%h, actual 0x%h", want, got);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	nscr_in_if  req();
	nscr_out_if rsp();

	nibble_serial_clock_registers_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	nibble_port_scoreboard expected_port = new();

	int unsigned words_sent;
	int unsigned quiet_cycles;
	int unsigned gap_odds;
	int unsigned rx_stall_odds;
	bit          settle;
	bit          took_word;
	access_t     seen_access;
	logic [63:0] noise;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Builds a word with the given kind and byte on top of a set of clock inputs.
	function automatic access_t make_access(logic op, logic [7:0] data, clk_item_t clock);
		access_t a;
		a.op = op;
		a.f = clock;
		a.f.write_byte = data;
		return a;
	endfunction

	// Random word of the given kind. Most clock inputs stay in their calendar range;
	// a quarter of them take any value the field width allows, so every bit toggles
	// and the out-of-range conversions are exercised as well.
	function automatic access_t draw_access(logic op);
		access_t a;
		noise = {$urandom, $urandom};
		a.op = op;
		a.f = noise[$bits(clk_item_t)-1:0];
		if ($urandom_range(0, 3) != 0) begin
			a.f.now_seconds = 6'($urandom_range(0, 59));
			a.f.now_minutes = 6'($urandom_range(0, 59));
			a.f.now_hours   = 5'($urandom_range(0, 23));
			a.f.now_day     = 5'($urandom_range(1, 31));
			a.f.now_month   = 4'($urandom_range(0, 11));
			a.f.now_weekday = 3'($urandom_range(0, 6));
		end
		return a;
	endfunction

	// Offers one word on the request channel and returns once it has been taken.
	// Inputs move on the falling edge only; the valid line stays up between
	// back-to-back words, and a random gap drops it first.
	task automatic send_access(input access_t a);
		if (!settle && $urandom_range(0, 99) < gap_odds) begin
			@(negedge clk);
			req.valid = 1'b0;
			repeat ($urandom_range(0, 10)) @(negedge clk);
		end
		@(negedge clk);
		req.op          = a.op;
		req.write_byte  = a.f.write_byte;
		req.now_seconds = a.f.now_seconds;
		req.now_minutes = a.f.now_minutes;
		req.now_hours   = a.f.now_hours;
		req.now_day     = a.f.now_day;
		req.now_month   = a.f.now_month;
		req.now_year    = a.f.now_year;
		req.now_weekday = a.f.now_weekday;
		req.valid       = 1'b1;
		do @(posedge clk); while (req.ready !== 1'b1);
		words_sent++;
		if (words_sent % 40 == 0) begin
			case ($urandom_range(0, 2))
				0: gap_odds = 0;
				1: gap_odds = 10;
				default: gap_odds = 35;
			endcase
		end
		settle = (words_sent >= TARGET_WORDS - SETTLE_WORDS);
	endtask

	// Result side: the ready line drops in random bursts, with the burst rate
	// changing now and then so that calm stretches occur too.
	initial begin
		rsp.ready = 1'b0;
		rx_stall_odds = 10;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 63) == 0) begin
				rx_stall_odds = $urandom_range(0, 2) * 15;
			end
			if (!settle && $urandom_range(0, 99) < rx_stall_odds) begin
				rsp.ready = 1'b0;
				repeat ($urandom_range(0, 10)) @(negedge clk);
			end else begin
				rsp.ready = 1'b1;
			end
		end
	end

	// Sampling on the rising edge sees the values from before the edge. A word
	// accepted on the request side updates the tracker; a word taken on the
	// result side is checked against the oldest nibble owed. The watchdog counts
	// cycles in which neither side moves a word.
	always @(posedge clk) begin
		if (arst_n) begin
			took_word = 1'b0;
			if (req.valid === 1'b1 && req.ready === 1'b1) begin
				seen_access.op            = req.op;
				seen_access.f.write_byte  = req.write_byte;
				seen_access.f.now_seconds = req.now_seconds;
				seen_access.f.now_minutes = req.now_minutes;
				seen_access.f.now_hours   = req.now_hours;
				seen_access.f.now_day     = req.now_day;
				seen_access.f.now_month   = req.now_month;
				seen_access.f.now_year    = req.now_year;
				seen_access.f.now_weekday = req.now_weekday;
				expected_port.note_request(seen_access);
				took_word = 1'b1;
			end
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				expected_port.check_response(rsp.read_nibble);
				took_word = 1'b1;
			end
			quiet_cycles = took_word ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		clk_item_t top_vals;
		clk_item_t max_vals;

		arst_n          = 1'b0;
		req.valid       = 1'b0;
		req.op          = OP_WRITE;
		req.write_byte  = '0;
		req.now_seconds = '0;
		req.now_minutes = '0;
		req.now_hours   = '0;
		req.now_day     = '0;
		req.now_month   = '0;
		req.now_year    = '0;
		req.now_weekday = '0;
		words_sent      = 0;
		quiet_cycles    = 0;
		gap_odds        = 10;
		settle          = 1'b0;

		// All field bits set, which pushes every clock input but the day past its
		// calendar range, and the largest in-range calendar values.
		top_vals = '1;
		max_vals = '{write_byte: 8'h00, now_seconds: 6'd59, now_minutes: 6'd59,
			now_hours: 5'd23, now_day: 5'd31, now_month: 4'd11, now_year: 8'd99,
			now_weekday: 3'd6};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// A read while the port waits for a register number answers zero and
		// leaves the phase alone.
		send_access(make_access(OP_READ, 8'hFF, top_vals));

		// Each clock register in turn. The select byte alternates its upper nibble
		// to show that only the low nibble picks the register, and the two reads
		// swap between out-of-range and in-range inputs.
		for (int r = 0; r < 7; r++) begin
			send_access(make_access(OP_WRITE, {(r % 2) ? 4'h0 : 4'hF, 4'(r)}, top_vals));
			send_access(make_access(OP_READ, 8'h00, (r % 2) ? max_vals : top_vals));
			send_access(make_access(OP_READ, 8'hFF, (r % 2) ? top_vals : max_vals));
		end

		// Plain storage: the high-nibble write keeps only its low nibble, so the
		// byte stored in the top register is F0; then read it back.
		send_access(make_access(OP_WRITE, 8'hFF, max_vals));
		send_access(make_access(OP_WRITE, 8'hFF, max_vals));
		send_access(make_access(OP_WRITE, 8'h00, max_vals));
		send_access(make_access(OP_WRITE, 8'h0F, top_vals));
		send_access(make_access(OP_READ, 8'h00, top_vals));
		send_access(make_access(OP_READ, 8'h00, top_vals));

		// Mostly complete three-word accesses: a select, then two words whose
		// kinds are drawn at random, so reads, stores, clock-register writes and
		// mixed read/write pairs all show up. The rest is loose words that break
		// the sequence and land in whatever phase the port is in.
		while (words_sent < TARGET_WORDS) begin
			if ($urandom_range(0, 9) < 8) begin
				send_access(draw_access(OP_WRITE));
				send_access(draw_access(1'($urandom_range(0, 1))));
				send_access(draw_access(1'($urandom_range(0, 1))));
			end else begin
				repeat ($urandom_range(1, 3)) send_access(draw_access(1'($urandom_range(0, 1))));
			end
		end

		@(negedge clk);
		req.valid = 1'b0;

		// Drain the owed nibbles, then let a stray result show before the verdict.
		while (expected_port.nibbles_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		if (expected_port.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
